/* hdl/sfmt_pkg.sv */
// ----------------------------------------------------------------------------
// sfmt_pkg
// Shared types, constants and the vector recursion of the SFMT19937 core.
// ----------------------------------------------------------------------------
package sfmt_pkg;

  localparam int WORD_COUNT = 624;
  localparam int VEC_COUNT  = WORD_COUNT / 4;
  localparam int ADDR_W     = 10;
  localparam int VEC_W      = 8;

  localparam logic [ADDR_W-1:0] LAST_WORD   = ADDR_W'(WORD_COUNT - 1);
  localparam logic [ADDR_W-1:0] WORD_END    = ADDR_W'(WORD_COUNT);
  localparam logic [ADDR_W-1:0] SKIP_LIMIT  = ADDR_W'(622);
  localparam logic [ADDR_W-1:0] INIT_C_ADDR = ADDR_W'(WORD_COUNT - 8);
  localparam logic [ADDR_W-1:0] INIT_D_ADDR = ADDR_W'(WORD_COUNT - 4);
  localparam logic [VEC_W-1:0]  LAST_VEC    = VEC_W'(VEC_COUNT - 1);
  localparam logic [VEC_W-1:0]  POS_VEC     = VEC_W'(488 / 4);

  localparam logic [31:0] SEED_MULT = 32'h6C07_8965;
  localparam logic [31:0] MSK0      = 32'hdfff_ffef;
  localparam logic [31:0] MSK1      = 32'hddfe_cb7f;
  localparam logic [31:0] MSK2      = 32'hbffa_ffff;
  localparam logic [31:0] MSK3      = 32'hbfff_fff6;

  typedef enum logic [1:0] {
    OP_SEED   = 2'd0,
    OP_NEXT32 = 2'd1,
    OP_NEXT64 = 2'd2,
    OP_SKIP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] seed;
  } cmd_t;

  typedef logic [3:0][31:0] word_vec_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef struct packed {
    logic              busy;
    logic [ADDR_W-1:0] read_index;
  } eng_status_t;

  // one 128-bit step of the SFMT recursion; c and d are the two newest vectors
  function automatic word_vec_t sfmt_recursion(word_vec_t a, word_vec_t b,
                                               word_vec_t c, word_vec_t d);
    word_vec_t n;
    n[3] = a[3] ^ (a[3] << 8) ^ (a[2] >> 24) ^ (c[3] >> 8)
         ^ ((b[3] >> 11) & MSK3) ^ (d[3] << 18);
    n[2] = a[2] ^ (a[2] << 8) ^ (a[1] >> 24) ^ (c[3] << 24) ^ (c[2] >> 8)
         ^ ((b[2] >> 11) & MSK2) ^ (d[2] << 18);
    n[1] = a[1] ^ (a[1] << 8) ^ (a[0] >> 24) ^ (c[2] << 24) ^ (c[1] >> 8)
         ^ ((b[1] >> 11) & MSK1) ^ (d[1] << 18);
    n[0] = a[0] ^ (a[0] << 8) ^ (c[1] << 24) ^ (c[0] >> 8)
         ^ ((b[0] >> 11) & MSK0) ^ (d[0] << 18);
    return n;
  endfunction

endpackage

/* hdl/sfmt_cmd_queue.sv */
// ----------------------------------------------------------------------------
// sfmt_cmd_queue
// Front end: accepts request transactions, classifies the op, queues them.
// ----------------------------------------------------------------------------
module sfmt_cmd_queue #(
  parameter int DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_op,
  input  logic [31:0]             in_seed_value,
  input  logic                    pop,
  output sfmt_pkg::cmd_t          head,
  output sfmt_pkg::queue_status_t status
);
  import sfmt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  cmd_t             cls;

  // every 2-bit code is a valid op
  always_comb begin
    cls.seed = in_seed_value;
    cls.op   = op_t'(in_op);
  end

  assign in_ready     = (count_r != FULL_CNT);
  assign push         = in_valid && in_ready;
  assign head         = entry_r[rd_ptr_r];
  assign status.empty = (count_r == '0);
  assign status.full  = !in_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* hdl/sfmt_engine.sv */
// ----------------------------------------------------------------------------
// sfmt_engine
// Back end: state store, seeding, certification, regeneration, word reads.
// ----------------------------------------------------------------------------
module sfmt_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sfmt_pkg::cmd_t        cmd,
  input  logic                  cmd_empty,
  output logic                  cmd_pop,
  input  logic [3:0][31:0]      parity,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [63:0]           out_value,
  output sfmt_pkg::eng_status_t status
);
  import sfmt_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SEED  = 9'b000000010,
    S_CERT  = 9'b000000100,
    S_RINIT = 9'b000001000,
    S_RRD   = 9'b000010000,
    S_RWR   = 9'b000100000,
    S_TAKE  = 9'b001000000,
    S_TAKEW = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_t;

  state_t            state_r;
  logic [ADDR_W-1:0] idx_r, cnt_r;
  op_t               op_r;
  logic [31:0]       seed_r, prev_r, lo_r;
  logic              half_r;
  logic [2:0]        sub_r;
  logic [VEC_W-1:0]  vi_r, bvi_r;
  word_vec_t         w_r, va_r, vb_r, c_r, d_r, nvec;
  logic              out_valid_r;
  logic [63:0]       out_value_r;

  logic [31:0]       mem [WORD_COUNT];
  logic [31:0]       rd_a_r, rd_b_r;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  logic [31:0]       wdata, seed_word, mix;
  logic [1:0]        cap;
  logic              inner, any_par;
  logic [1:0]        sel;
  logic [31:0]       flip;

  assign mix       = prev_r ^ (prev_r >> 30);
  assign seed_word = (cnt_r == '0) ? seed_r : 32'(SEED_MULT * mix) + 32'(cnt_r);
  assign nvec      = sfmt_recursion(va_r, vb_r, c_r, d_r);
  assign cap       = 2'(sub_r - 3'd1);
  assign inner     = ^((w_r[0] & parity[0]) ^ (w_r[1] & parity[1])
                     ^ (w_r[2] & parity[2]) ^ (w_r[3] & parity[3]));
  assign any_par   = |parity;

  always_comb begin
    if (parity[0] != '0)      sel = 2'd0;
    else if (parity[1] != '0) sel = 2'd1;
    else if (parity[2] != '0) sel = 2'd2;
    else                      sel = 2'd3;
    flip = parity[sel] & (~parity[sel] + 32'd1);
  end

  always_comb begin
    we      = 1'b0;
    waddr   = cnt_r;
    wdata   = seed_word;
    raddr_a = idx_r;
    raddr_b = idx_r;
    case (state_r)
      S_SEED: we = 1'b1;
      S_CERT: begin
        we    = !inner && any_par;
        waddr = {{(ADDR_W-2){1'b0}}, sel};
        wdata = w_r[sel] ^ flip;
      end
      S_RINIT: begin
        raddr_a = INIT_C_ADDR + {{(ADDR_W-2){1'b0}}, sub_r[1:0]};
        raddr_b = INIT_D_ADDR + {{(ADDR_W-2){1'b0}}, sub_r[1:0]};
      end
      S_RRD: begin
        raddr_a = {vi_r, sub_r[1:0]};
        raddr_b = {bvi_r, sub_r[1:0]};
      end
      S_RWR: begin
        we    = 1'b1;
        waddr = {vi_r, sub_r[1:0]};
        wdata = nvec[sub_r[1:0]];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  assign cmd_pop = (state_r == S_IDLE) && !cmd_empty && !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
      sub_r       <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd_pop) begin
            op_r   <= cmd.op;
            seed_r <= cmd.seed;
            half_r <= 1'b0;
            sub_r  <= '0;
            case (cmd.op)
              OP_SEED: begin
                cnt_r   <= '0;
                state_r <= S_SEED;
              end
              OP_NEXT32, OP_NEXT64: state_r <= S_TAKE;
              default: begin
                if (idx_r >= SKIP_LIMIT) begin
                  state_r <= S_RINIT;
                end else begin
                  idx_r       <= idx_r + 2'd2;
                  out_valid_r <= 1'b1;
                  out_value_r <= '0;
                end
              end
            endcase
          end
        end
        S_SEED: begin
          prev_r <= seed_word;
          if (cnt_r < ADDR_W'(4)) begin
            w_r[cnt_r[1:0]] <= seed_word;
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_WORD) begin
            state_r <= S_CERT;
          end
        end
        S_CERT: begin
          sub_r   <= '0;
          state_r <= S_RINIT;
        end
        S_RINIT: begin
          if (sub_r != 3'd0) begin
            c_r[cap] <= rd_a_r;
            d_r[cap] <= rd_b_r;
          end
          if (sub_r == 3'd4) begin
            sub_r   <= '0;
            vi_r    <= '0;
            bvi_r   <= POS_VEC;
            state_r <= S_RRD;
          end else begin
            sub_r <= sub_r + 3'd1;
          end
        end
        S_RRD: begin
          if (sub_r != 3'd0) begin
            va_r[cap] <= rd_a_r;
            vb_r[cap] <= rd_b_r;
          end
          if (sub_r == 3'd4) begin
            sub_r   <= '0;
            state_r <= S_RWR;
          end else begin
            sub_r <= sub_r + 3'd1;
          end
        end
        S_RWR: begin
          if (sub_r == 3'd3) begin
            sub_r <= '0;
            c_r   <= d_r;
            d_r   <= nvec;
            vi_r  <= vi_r + 1'b1;
            bvi_r <= (bvi_r == LAST_VEC) ? '0 : bvi_r + 1'b1;
            if (vi_r == LAST_VEC) begin
              idx_r <= '0;
              if (op_r == OP_NEXT32 || op_r == OP_NEXT64) begin
                state_r <= S_TAKE;
              end else begin
                out_valid_r <= 1'b1;
                out_value_r <= '0;
                state_r     <= S_IDLE;
              end
            end else begin
              state_r <= S_RRD;
            end
          end else begin
            sub_r <= sub_r + 3'd1;
          end
        end
        S_TAKE: begin
          if (idx_r >= WORD_END) begin
            sub_r   <= '0;
            state_r <= S_RINIT;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_TAKEW;
          end
        end
        S_TAKEW: begin
          if (op_r == OP_NEXT64 && !half_r) begin
            lo_r    <= rd_a_r;
            half_r  <= 1'b1;
            state_r <= S_TAKE;
          end else begin
            out_valid_r <= 1'b1;
            out_value_r <= (op_r == OP_NEXT64) ? {rd_a_r, lo_r} : {32'd0, rd_a_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value         = out_value_r;
  assign status.busy       = (state_r != S_IDLE);
  assign status.read_index = idx_r;

endmodule

/* hdl/sfmt19937_random_generator_core.sv */
// ----------------------------------------------------------------------------
// sfmt19937_random_generator_core
// SFMT19937 generator: request queue in front, state engine behind it.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request channel (valid/ready). in_op 0 seed, 1 next32, 2 next64,
//           3 skip; in_seed_value is used by seed only.
//   out_* : one result transaction per request, in order. out_random_value
//           is zero for seed and skip, upper half zero for next32.
//   cfg_* : parity mask writes (index 0..3), always ready; write while idle.
// Sequencing:
//   next32 and next64 results come from the registered word read (address,
//   then data), one word for next32, two for next64; a skip is answered
//   from idle unless it needs a refill. A request starts only after the
//   previous result is taken. A refill of the 624-word store first reads
//   the two newest vectors, then does four word reads, a wait and four word
//   writes per 128-bit vector, over 156 vectors.
//   Seed fills the 624 words first (one multiply per word), then runs
//   certification, before its refill.
// Reset: read index to zero, parity masks to their defaults, queue empty.
//   Store contents are undefined until the first seed.
// Stall: a result waits in the output register; the front queue keeps taking
//   requests until it is full, then in_ready drops.
// ----------------------------------------------------------------------------
module sfmt19937_random_generator_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_seed_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_random_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sfmt_pkg::*;

  // period certification masks
  logic [3:0][31:0] parity_r;
  cmd_t             head;
  queue_status_t    q_status;
  eng_status_t      e_status;
  logic             pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r[0] <= 32'h0000_0001;
      parity_r[1] <= 32'h0000_0000;
      parity_r[2] <= 32'h0000_0000;
      parity_r[3] <= 32'h13C9_E684;
    end else if (cfg_valid && cfg_ready) begin
      parity_r[cfg_index] <= cfg_data;
    end
  end

  // front: accept and classify
  sfmt_cmd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_seed_value(in_seed_value),
    .pop          (pop),
    .head         (head),
    .status       (q_status)
  );

  // back: store, refill, reads; owns the output register
  sfmt_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (head),
    .cmd_empty(q_status.empty),
    .cmd_pop  (pop),
    .parity   (parity_r),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_value(out_random_value),
    .status   (e_status)
  );

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_status.empty) else $error("pop from empty queue");
  a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !out_valid) else $error("request started with result pending");
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    e_status.read_index <= WORD_END) else $error("read index out of range");
  a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !e_status.busy) else $error("pop while engine busy");
`endif

endmodule

/* bench/sfmt19937_random_generator_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmt19937_random_generator_core_test
// Self-checking bench: directed table plus random ops, scored against an
// in-bench SFMT19937 model under random idling and back-pressure.
// ----------------------------------------------------------------------------
module sfmt19937_random_generator_core_test;
  import sfmt_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = OP_NEXT32;
  logic [31:0] in_seed_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_random_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sfmt19937_random_generator_core u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---- predictor state ----
  logic [31:0] gen_words [WORD_COUNT];
  int unsigned gen_index;
  logic [31:0] gen_parity [4];
  logic [63:0] value_queue [$];

  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_seed = 0;
  int n_wrap = 0;
  bit quiet = 1'b0;      // no idling in the final stretch
  bit hold_rx = 1'b0;    // long receiver hold-off request

  // whole-store refill, same loop order as the vector recursion
  function automatic void gen_refill();
    int a, b, c, d;
    logic [31:0] w3, w2, w1, w0;
    a = 0; b = 488; c = WORD_COUNT - 8; d = WORD_COUNT - 4;
    while (a < WORD_COUNT) begin
      w3 = gen_words[a+3] ^ (gen_words[a+3] << 8) ^ (gen_words[a+2] >> 24)
         ^ (gen_words[c+3] >> 8) ^ ((gen_words[b+3] >> 11) & 32'hbffffff6)
         ^ (gen_words[d+3] << 18);
      w2 = gen_words[a+2] ^ (gen_words[a+2] << 8) ^ (gen_words[a+1] >> 24)
         ^ (gen_words[c+3] << 24) ^ (gen_words[c+2] >> 8)
         ^ ((gen_words[b+2] >> 11) & 32'hbffaffff) ^ (gen_words[d+2] << 18);
      w1 = gen_words[a+1] ^ (gen_words[a+1] << 8) ^ (gen_words[a] >> 24)
         ^ (gen_words[c+2] << 24) ^ (gen_words[c+1] >> 8)
         ^ ((gen_words[b+1] >> 11) & 32'hddfecb7f) ^ (gen_words[d+1] << 18);
      w0 = gen_words[a] ^ (gen_words[a] << 8) ^ (gen_words[c+1] << 24)
         ^ (gen_words[c] >> 8) ^ ((gen_words[b] >> 11) & 32'hdfffffef)
         ^ (gen_words[d] << 18);
      gen_words[a+3] = w3; gen_words[a+2] = w2;
      gen_words[a+1] = w1; gen_words[a] = w0;
      c = d; d = a; a += 4; b += 4;
      if (b >= WORD_COUNT) b = 0;
    end
    gen_index = 0;
    n_wrap++;
  endfunction

  function automatic void gen_seed(input logic [31:0] s);
    logic [31:0] p, inner;
    bit done;
    gen_words[0] = s;
    for (int i = 1; i < WORD_COUNT; i++) begin
      p = gen_words[i-1];
      gen_words[i] = 32'h6C078965 * (p ^ (p >> 30)) + 32'(i);
    end
    inner = '0;
    for (int i = 0; i < 4; i++) inner ^= gen_words[i] & gen_parity[i];
    // odd parity means the period is already certified
    if (^inner == 1'b0) begin
      done = 1'b0;
      for (int i = 0; i < 4; i++)
        for (int k = 0; k < 32; k++)
          if (!done && gen_parity[i][k]) begin
            gen_words[i][k] = ~gen_words[i][k];
            done = 1'b1;
          end
    end
    gen_refill();
  endfunction

  function automatic logic [31:0] gen_take();
    logic [31:0] v;
    if (gen_index >= WORD_COUNT) gen_refill();
    v = gen_words[gen_index];
    gen_index++;
    return v;
  endfunction

  function automatic logic [63:0] gen_value(op_t op, logic [31:0] s);
    logic [31:0] lo, hi;
    case (op)
      OP_SEED: begin
        gen_seed(s);
        n_seed++;
        return '0;
      end
      OP_NEXT32: return {32'd0, gen_take()};
      OP_NEXT64: begin
        lo = gen_take();
        hi = gen_take();
        return {hi, lo};
      end
      default: begin
        if (gen_index >= SKIP_LIMIT) gen_refill();
        else gen_index += 2;
        return '0;
      end
    endcase
  endfunction

  // ---- driver helpers ----
  task automatic send_op(op_t op, logic [31:0] s);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_seed_value <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    value_queue.push_back(gen_value(op, s));
    n_sent++;
  endtask

  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (value_queue.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    // seed/skip refills may still run: let the longest one pass
    repeat (2200) @(posedge clk);
  endtask

  task automatic write_parity(logic [1:0] idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    gen_parity[idx] = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---- receiver with random stalls ----
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_rx = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 9);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // ---- scoreboard ----
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_recv++;
      if (value_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time,
                 out_random_value);
        errors++;
      end else begin
        if (out_random_value !== value_queue[0]) begin
          $display("%0t: random_value mismatch, expected %h, actual %h", $time,
                   value_queue[0], out_random_value);
          errors++;
        end
        void'(value_queue.pop_front());
      end
    end
  end

  // directed table: op, seed, check-against-typed, typed value
  typedef struct {
    op_t         op;
    logic [31:0] seed;
    bit          typed;
    logic [63:0] value;
  } dir_row_t;

  dir_row_t dir_rows [] = '{
    '{OP_SEED,   32'h0000_0000, 1'b1, 64'd0},
    '{OP_NEXT32, 32'h0,         1'b0, 64'd0},
    '{OP_NEXT64, 32'h0,         1'b0, 64'd0},
    '{OP_SKIP,   32'hFFFF_FFFF, 1'b1, 64'd0},
    '{OP_SEED,   32'hFFFF_FFFF, 1'b1, 64'd0},
    '{OP_NEXT64, 32'h0,         1'b0, 64'd0},
    '{OP_SEED,   32'h0000_1571, 1'b1, 64'd0},
    '{OP_NEXT32, 32'h0,         1'b0, 64'd0},
    '{OP_NEXT32, 32'h0,         1'b0, 64'd0},
    '{OP_SKIP,   32'h0,         1'b1, 64'd0},
    '{OP_NEXT64, 32'h0,         1'b0, 64'd0},
    '{OP_SEED,   32'hA5A5_5A5A, 1'b1, 64'd0}
  };

  // walk read index to a given position with next32/skip
  task automatic walk_to(int unsigned pos);
    while (gen_index != pos) begin
      if (gen_index + 2 <= pos && gen_index < SKIP_LIMIT) send_op(OP_SKIP, '0);
      else send_op(OP_NEXT32, '0);
    end
  endtask

  task automatic random_phase(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2) send_op(OP_SEED, $urandom());
      else if (r < 40) send_op(OP_NEXT32, $urandom());
      else if (r < 80) send_op(OP_NEXT64, $urandom());
      else send_op(OP_SKIP, $urandom());
    end
  endtask

  initial begin
    logic [63:0] typed_val;
    gen_parity[0] = 32'h1; gen_parity[1] = '0; gen_parity[2] = '0;
    gen_parity[3] = 32'h13C9E684;
    gen_index = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, default parity masks
    foreach (dir_rows[i]) begin
      send_op(dir_rows[i].op, dir_rows[i].seed);
      typed_val = value_queue[$];
      if (dir_rows[i].typed) begin
        if (typed_val !== dir_rows[i].value) begin
          // predictor itself must agree with the obvious values
          $display("%0t: table row %0d expected %h, actual %h", $time, i,
                   dir_rows[i].value, typed_val);
          errors++;
        end
        value_queue[$] = dir_rows[i].value;
      end
    end
    // skip right at the end of the store, and next64 straddling a refill
    walk_to(622); send_op(OP_SKIP, '0);
    walk_to(623); send_op(OP_NEXT64, '0);
    walk_to(621); send_op(OP_SKIP, '0); send_op(OP_NEXT32, '0);
    drain();

    // all masks zero: certification leaves the state alone
    for (int i = 0; i < 4; i++) write_parity(2'(i), 32'h0);
    send_op(OP_SEED, 32'h0); send_op(OP_NEXT64, '0);
    send_op(OP_SEED, 32'hFFFF_FFFF); send_op(OP_NEXT64, '0);
    drain();

    // all masks ones, then random masks
    for (int i = 0; i < 4; i++) write_parity(2'(i), 32'hFFFF_FFFF);
    random_phase(80);
    drain();
    for (int i = 0; i < 4; i++) write_parity(2'(i), $urandom());
    hold_rx = 1'b1;   // receiver holds off while we keep pushing
    random_phase(120);
    drain();

    // high-bit-only masks force the flip search to the last word
    write_parity(2'd0, 32'h0); write_parity(2'd1, 32'h0);
    write_parity(2'd2, 32'h0); write_parity(2'd3, 32'h8000_0000);
    random_phase(60);
    drain();

    // back to reset values, final part with no idling
    write_parity(2'd0, 32'h1); write_parity(2'd1, 32'h0);
    write_parity(2'd2, 32'h0); write_parity(2'd3, 32'h13C9E684);
    quiet = 1'b1;
    random_phase(90);
    drain();

    if (value_queue.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, value_queue.size());
      errors++;
    end
    $display("Covered %0d requests, %0d results, %0d seeds, %0d store refills,",
             n_sent, n_recv, n_seed, n_wrap);
    $display("six parity settings, random idling and a long output stall.");
    if (errors == 0) begin
      $display("PASS sfmt19937_random_generator_core");
    end else begin
      $display("FAIL sfmt19937_random_generator_core");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL sfmt19937_random_generator_core");
    $finish;
  end

endmodule
